// File: rtl/form_key_value_url_decoder_core_assert.svh
// Assertion macros used by the bundle queue of the url form decoder RTL.
`ifndef FORM_KEY_VALUE_URL_DECODER_CORE_ASSERT_SVH
`define FORM_KEY_VALUE_URL_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define FKVUD_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FKVUD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fkvud_pkg.sv
// Shared types, constants and helper functions of the url form decoder.
package fkvud_pkg;

  localparam int VALUE_MAX_DEF = 512;
  localparam int MAX_RES       = 4;
  localparam int RES_IDX_W     = $clog2(MAX_RES);
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_KEY   = 2'd1;
  localparam logic [1:0] ST_STRAY = 2'd2;
  localparam logic [1:0] ST_LONG  = 2'd3;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PCT   = 2'd1;
  localparam logic [1:0] PEND_DIGIT = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CASE_BIT = 8'hdf;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]   res;
    logic [RES_IDX_W-1:0] last_idx;
  } bundle_t;

  function automatic logic [7:0] key_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h6b;
      2'd1:    c = 8'h65;
      default: c = 8'h79;
    endcase
    return c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41) begin
      v = (c & CASE_BIT) - 8'h41 + 8'd10;
    end else begin
      v = c - 8'h30;
    end
    return v[3:0];
  endfunction

endpackage

// File: rtl/fkvud_front.sv
// Front end: parses body bytes and builds the result bundle of each transfer.
module fkvud_front #(
  parameter int VALUE_MAX = fkvud_pkg::VALUE_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // in_byte
  input  logic              in_tlast,   // end_of_body
  input  logic              q_full,
  output logic              push,
  output fkvud_pkg::bundle_t push_data
);
  import fkvud_pkg::*;

  localparam int RAW_W = $clog2(VALUE_MAX + 1);

  logic [2:0]       pos_r, pos_nxt;
  logic             key_r, key_nxt;
  logic [1:0]       pc_r, pc_nxt;
  logic [7:0]       dig_r, dig_nxt;
  logic [RAW_W-1:0] raw_r, raw_nxt;
  logic             disc_r, disc_nxt;

  logic             acc;
  logic [2:0]       n;
  logic [1:0]       err;
  logic             sep;
  logic             hx;
  logic             do_plain;
  res_t [MAX_RES-1:0] res;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign sep       = (in_tdata == CH_AMP) || (in_tdata == CH_EQ);
  assign hx        = is_hex(in_tdata);

  always_comb begin
    pos_nxt  = pos_r;
    key_nxt  = key_r;
    pc_nxt   = pc_r;
    dig_nxt  = dig_r;
    raw_nxt  = raw_r;
    disc_nxt = disc_r;
    res      = '0;
    n        = 3'd0;
    err      = ST_OK;
    do_plain = 1'b0;
    if (disc_r) begin
      if (in_tlast) begin
        disc_nxt = 1'b0;
        pos_nxt  = 3'd0;
        key_nxt  = 1'b1;
        pc_nxt   = PEND_NONE;
        dig_nxt  = 8'd0;
        raw_nxt  = '0;
      end
    end else begin
      if (pos_r < 3'd3) begin
        if (sep) begin
          err = ST_STRAY;
        end else begin
          if (in_tdata != key_char(pos_r[1:0])) key_nxt = 1'b0;
          pos_nxt = pos_r + 3'd1;
        end
      end else if (pos_r == 3'd3) begin
        if (!key_r || (in_tdata != CH_EQ)) err = ST_KEY;
        else pos_nxt = 3'd4;
      end else begin
        if (raw_r >= RAW_W'(VALUE_MAX)) begin
          err = ST_LONG;
        end else if (sep) begin
          err = ST_STRAY;
        end else begin
          raw_nxt = raw_r + RAW_W'(1);
          case (pc_r)
            PEND_PCT: begin
              if (hx) begin
                pc_nxt  = PEND_DIGIT;
                dig_nxt = in_tdata;
              end else begin
                res[n[1:0]] = '{CH_PCT, 1'b1, ST_OK, 1'b0};
                n = n + 3'd1;
                do_plain = 1'b1;
              end
            end
            PEND_DIGIT: begin
              pc_nxt = PEND_NONE;
              if (hx) begin
                res[n[1:0]] = '{{hex_val(dig_r), hex_val(in_tdata)}, 1'b1, ST_OK, 1'b0};
                n = n + 3'd1;
              end else begin
                res[n[1:0]] = '{CH_PCT, 1'b1, ST_OK, 1'b0};
                n = n + 3'd1;
                res[n[1:0]] = '{dig_r, 1'b1, ST_OK, 1'b0};
                n = n + 3'd1;
                do_plain = 1'b1;
              end
            end
            default: do_plain = 1'b1;
          endcase
          if (do_plain) begin
            if (in_tdata == CH_PCT) begin
              pc_nxt = PEND_PCT;
            end else begin
              pc_nxt = PEND_NONE;
              res[n[1:0]] = '{(in_tdata == CH_PLUS) ? CH_SPACE : in_tdata,
                              1'b1, ST_OK, 1'b0};
              n = n + 3'd1;
            end
          end
        end
      end
      if (err != ST_OK) begin
        res[n[1:0]] = '{8'd0, 1'b0, err, 1'b1};
        n = n + 3'd1;
        disc_nxt = !in_tlast;
      end else if (in_tlast) begin
        if (pc_nxt == PEND_PCT) begin
          res[n[1:0]] = '{CH_PCT, 1'b1, ST_OK, 1'b0};
          n = n + 3'd1;
        end else if (pc_nxt == PEND_DIGIT) begin
          res[n[1:0]] = '{CH_PCT, 1'b1, ST_OK, 1'b0};
          n = n + 3'd1;
          res[n[1:0]] = '{dig_nxt, 1'b1, ST_OK, 1'b0};
          n = n + 3'd1;
        end
        res[n[1:0]] = '{8'd0, 1'b0, ST_OK, 1'b1};
        n = n + 3'd1;
      end
      if ((err != ST_OK) || in_tlast) begin
        pos_nxt = 3'd0;
        key_nxt = 1'b1;
        pc_nxt  = PEND_NONE;
        dig_nxt = 8'd0;
        raw_nxt = '0;
      end
    end
  end

  assign push      = acc && (n != 3'd0);
  assign push_data = '{res: res, last_idx: RES_IDX_W'(n - 3'd1)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 3'd0;
      key_r  <= 1'b1;
      pc_r   <= PEND_NONE;
      dig_r  <= 8'd0;
      raw_r  <= '0;
      disc_r <= 1'b0;
    end else if (acc) begin
      pos_r  <= pos_nxt;
      key_r  <= key_nxt;
      pc_r   <= pc_nxt;
      dig_r  <= dig_nxt;
      raw_r  <= raw_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

// File: rtl/fkvud_queue.sv
// Bundle queue between the parser and the output sequencer.
`include "form_key_value_url_decoder_core_assert.svh"
module fkvud_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fkvud_pkg::bundle_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output fkvud_pkg::bundle_t head
);
  import fkvud_pkg::*;

  bundle_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `FKVUD_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full || pop, "push into full queue")
  `FKVUD_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, head_valid, "pop from empty queue")
  `FKVUD_ASSERT_NEXT(a_cnt_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + QCNT_W'(1), "count did not advance")
  `FKVUD_ASSERT_NOW(a_ptr_gap, clk, rst_n, 1'b1, (wr_r == rd_r) == ((cnt_r == '0) || full), "pointer mismatch")

endmodule

// File: rtl/fkvud_back.sv
// Back end: sends the results of the head bundle one transfer at a time.
module fkvud_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  fkvud_pkg::bundle_t head,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // out_byte
  output logic [2:0]         out_tuser,  // data_valid, status[1:0]
  output logic               out_tlast   // run_last
);
  import fkvud_pkg::*;

  logic [RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                 xfer;
  res_t                 cur;

  assign cur        = head.res[idx_r];
  assign out_tvalid = head_valid;
  assign out_tdata  = cur.data;
  assign out_tuser  = {cur.status, cur.valid};
  assign out_tlast  = cur.last;
  assign xfer       = out_tvalid && out_tready;
  assign pop        = xfer && (idx_r == head.last_idx);

  always_comb begin
    idx_nxt = idx_r;
    if (pop) idx_nxt = '0;
    else if (xfer) idx_nxt = idx_r + RES_IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// File: rtl/form_key_value_url_decoder_core.sv
// Top level of the streaming decoder for a key=value url-encoded form body.
// Usage:
//   in_*  : body bytes, one per transfer; in_tlast flags the last byte.
//   out_* : results; out_tdata is a decoded value byte when out_tuser[0] is 1,
//           out_tuser[2:1] is the status, and out_tlast closes each body.
//   A body gives its decoded value bytes, then one closing status transfer.
//   On an error the status goes out at once and the rest of the body is
//   dropped; the receiver discards the data already seen for that body.
// Each result is registered in the bundle queue before it is offered.
// Throughput: one input byte per cycle while the queue has room; the output side
//   sends one result per cycle while out_tready is high; a byte that expands
//   (a broken escape, or the flush at body end) gives up to four results.
// A four-entry bundle queue sits between parser and output sequencer; when
//   the receiver stalls it fills and in_tready drops, then input stalls.
// Reset empties the queue and returns the parser to the start of a body.
module form_key_value_url_decoder_core #(
  parameter int VALUE_MAX = fkvud_pkg::VALUE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // in_byte
  input  logic       in_tlast,    // end_of_body
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic [2:0] out_tuser,   // data_valid, status[1:0]
  output logic       out_tlast    // run_last
);
  import fkvud_pkg::*;

  logic    q_full;
  logic    push;
  bundle_t push_data;
  logic    pop;
  logic    head_valid;
  bundle_t head;

  fkvud_front #(
    .VALUE_MAX(VALUE_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  fkvud_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  fkvud_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// File: tb/form_key_value_url_decoder_core_checker.sv
// Checker for the url form decoder: predicts each transfer's results and compares them.
`timescale 1ns / 100ps

module form_key_value_url_decoder_core_checker #(
  parameter int VALUE_MAX = fkvud_pkg::VALUE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,    // in_byte
  input  logic       in_tlast,    // end_of_body
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,   // out_byte
  input  logic [2:0] out_tuser,   // data_valid, status[1:0]
  input  logic       out_tlast,   // run_last
  output int         fail_count,
  output int         outstanding,
  output int         checked_count,
  output int         error_closes
);
  import fkvud_pkg::*;

  localparam logic [2:0]  HDR_EQ    = 3'd3;
  localparam logic [2:0]  HDR_VALUE = 3'd4;
  localparam logic [23:0] KEY_WORD  = {8'h79, 8'h65, 8'h6b};

  res_t       decoded_q[$];
  res_t       want;
  logic [2:0] hdr_pos;
  logic       key_ok;
  logic [1:0] esc_cnt;
  logic [7:0] esc_digit;
  logic [9:0] value_len;
  logic       dropping;
  int         fails = 0;
  int         checked = 0;
  int         errs = 0;

  task automatic clear_parser();
    hdr_pos   = 3'd0;
    key_ok    = 1'b1;
    esc_cnt   = PEND_NONE;
    esc_digit = 8'h00;
    value_len = 10'd0;
  endtask

  task automatic push_res(input logic [7:0] b, input logic v, input logic [1:0] st,
                          input logic l);
    res_t r;
    r.data   = b;
    r.valid  = v;
    r.status = st;
    r.last   = l;
    decoded_q.push_back(r);
  endtask

  function automatic logic hex_digit(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return ((c >= 8'h30) && (c <= 8'h39)) || ((lc >= 8'h61) && (lc <= 8'h66));
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) v = c;
    else v = (c | 8'h20) - 8'h57;
    return v[3:0];
  endfunction

  task automatic plain_char(input logic [7:0] c);
    if (c == CH_PLUS) push_res(CH_SPACE, 1'b1, ST_OK, 1'b0);
    else if (c == CH_PCT) esc_cnt = PEND_PCT;
    else push_res(c, 1'b1, ST_OK, 1'b0);
  endtask

  task automatic value_char(input logic [7:0] c);
    if (esc_cnt == PEND_PCT) begin
      if (hex_digit(c)) begin
        esc_cnt   = PEND_DIGIT;
        esc_digit = c;
      end else begin
        esc_cnt = PEND_NONE;
        push_res(CH_PCT, 1'b1, ST_OK, 1'b0);
        plain_char(c);
      end
    end else if (esc_cnt == PEND_DIGIT) begin
      esc_cnt = PEND_NONE;
      if (hex_digit(c)) begin
        push_res({nibble(esc_digit), nibble(c)}, 1'b1, ST_OK, 1'b0);
      end else begin
        push_res(CH_PCT, 1'b1, ST_OK, 1'b0);
        push_res(esc_digit, 1'b1, ST_OK, 1'b0);
        plain_char(c);
      end
    end else begin
      esc_cnt = PEND_NONE;
      plain_char(c);
    end
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic eob);
    logic [1:0] err;
    err = ST_OK;
    if (dropping) begin
      if (eob) begin
        dropping = 1'b0;
        clear_parser();
      end
    end else begin
      if (hdr_pos < HDR_EQ) begin
        if (c == CH_AMP || c == CH_EQ) begin
          err = ST_STRAY;
        end else begin
          if (c != KEY_WORD[hdr_pos*8 +: 8]) key_ok = 1'b0;
          hdr_pos = hdr_pos + 3'd1;
        end
      end else if (hdr_pos == HDR_EQ) begin
        if (!key_ok || c != CH_EQ) err = ST_KEY;
        else hdr_pos = HDR_VALUE;
      end else begin
        if (value_len >= VALUE_MAX) begin
          err = ST_LONG;
        end else if (c == CH_AMP || c == CH_EQ) begin
          err = ST_STRAY;
        end else begin
          value_len = value_len + 10'd1;
          value_char(c);
        end
      end

      if (err != ST_OK) begin
        push_res(8'h00, 1'b0, err, 1'b1);
        clear_parser();
        dropping = !eob;
      end else if (eob) begin
        if (esc_cnt == PEND_PCT) begin
          push_res(CH_PCT, 1'b1, ST_OK, 1'b0);
        end else if (esc_cnt == PEND_DIGIT) begin
          push_res(CH_PCT, 1'b1, ST_OK, 1'b0);
          push_res(esc_digit, 1'b1, ST_OK, 1'b0);
        end
        push_res(8'h00, 1'b0, ST_OK, 1'b1);
        clear_parser();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      decoded_q.delete();
      dropping = 1'b0;
      clear_parser();
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("result with none pending: out_tdata %0h out_tuser %0h out_tlast %0b",
                 out_tdata, out_tuser, out_tlast);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          checked++;
          if (!want.valid && want.status != ST_OK) errs++;
          if (out_tdata !== want.data) begin
            $error("out_byte mismatch: expected %0h, actual %0h", want.data, out_tdata);
            fails++;
          end
          if (out_tuser[0] !== want.valid) begin
            $error("data_valid mismatch: expected %0b, actual %0b", want.valid, out_tuser[0]);
            fails++;
          end
          if (out_tuser[2:1] !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_tuser[2:1]);
            fails++;
          end
          if (out_tlast !== want.last) begin
            $error("run_last mismatch: expected %0b, actual %0b", want.last, out_tlast);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    outstanding   <= decoded_q.size();
    checked_count <= checked;
    error_closes  <= errs;
  end

endmodule

// File: tb/form_key_value_url_decoder_core_tb.sv
// Testbench top for the url form decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module form_key_value_url_decoder_core_tb;
  import fkvud_pkg::*;

  localparam int VMAX      = 12;
  localparam int LONG_HOLD = 60;
  localparam int RAND_ITEMS = 170;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // in_byte
  logic       in_tlast;    // end_of_body
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // out_byte
  logic [2:0] out_tuser;   // data_valid, status[1:0]
  logic       out_tlast;   // run_last

  int fail_count;
  int outstanding;
  int checked_count;
  int error_closes;

  logic       calm;
  logic       stall_req;
  logic       stall_done;
  logic [7:0] body_q[$];
  int         bodies = 0;
  int         bytes_sent = 0;

  form_key_value_url_decoder_core #(.VALUE_MAX(VMAX)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  form_key_value_url_decoder_core_checker #(.VALUE_MAX(VMAX)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .error_closes  (error_closes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("form_key_value_url_decoder_core test failed");
    $finish;
  end

  // mostly short, a few long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  initial begin : receiver
    int hold;
    hold = 0;
    out_tready <= 1'b0;
    stall_done <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_req && !stall_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_done <= 1'b1;
      end else if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else if (calm || $urandom_range(0, 99) < 75) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        hold = idle_len() - 1;
      end
      @(posedge clk);
    end
  end

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(r + 8'h30);
    if (r < 16) return 8'(r - 10 + 8'h41);
    return 8'(r - 16 + 8'h61);
  endfunction

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic put_value(input int raw_len);
    int n;
    int r;
    n = 0;
    while (n < raw_len) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        body_q.push_back(CH_PCT);
        body_q.push_back(hex_char());
        body_q.push_back(hex_char());
        n += 3;
      end else if (r < 35) begin
        body_q.push_back(CH_PLUS);
        n++;
      end else if (r < 42) begin
        body_q.push_back(CH_PCT);
        body_q.push_back($urandom_range(0, 3) == 0 ? hex_char() : 8'($urandom_range(0, 255)));
        n += 2;
      end else if (r < 45) begin
        body_q.push_back($urandom_range(0, 1) ? CH_AMP : CH_EQ);
        n++;
      end else begin
        body_q.push_back(8'($urandom_range(0, 255)));
        n++;
      end
    end
  endtask

  task automatic send_body();
    int k;
    int gap;
    for (k = 0; k < body_q.size(); k++) begin
      gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= body_q[k];
      in_tlast  <= (k == body_q.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    bodies++;
    bytes_sent += body_q.size();
    body_q.delete();
  endtask

  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int i;
    int r;
    int start_bytes;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    calm      <= 1'b0;
    stall_req <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short bodies that end inside the key, one with wrong key bytes
    put_text("k");
    send_body();
    put_text("xy");
    send_body();
    // extreme bytes, plus, broken escapes, escape flushed at end
    put_text("key=");
    body_q.push_back(8'h00);
    body_q.push_back(8'hff);
    put_text("+%4g%z%4%");
    send_body();
    // bad fourth byte, rest of body dropped
    put_text("key&z");
    send_body();
    // stray separator in the key
    put_text("k=");
    send_body();

    drain();

    // receiver holds off while a gapless body fills the queue
    calm      <= 1'b1;
    stall_req <= 1'b1;
    put_text("key=abcd+%41efgh");
    send_body();
    drain();
    calm <= 1'b0;

    start_bytes = bytes_sent;
    i = 0;
    while (bytes_sent - start_bytes < RAND_ITEMS) begin
      if (i % 8 == 0) calm <= ($urandom_range(0, 3) == 0);
      if (i % 23 == 22) drain();
      r = $urandom_range(0, 99);
      if (r < 70) begin
        put_text("key=");
        if ($urandom_range(0, 99) < 85) put_value($urandom_range(0, 8));
        else put_value($urandom_range(VMAX - 2, VMAX + 3));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) begin
          if (body_q.size() < 4 && $urandom_range(0, 99) < 60)
            body_q.push_back(body_q.size() == 3 ? CH_EQ : ((body_q.size() == 0) ? 8'h6b :
                             ((body_q.size() == 1) ? 8'h65 : 8'h79)));
          else
            body_q.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) body_q.push_back(8'($urandom_range(0, 255)));
      end
      send_body();
      i++;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d bodies in %0d byte transfers; checked %0d results, %0d error closes.",
             bodies, bytes_sent, checked_count, error_closes);
    $display("Covered short bodies, bad keys, stray separators, long values and escapes.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("form_key_value_url_decoder_core test passed");
    end else begin
      $display("form_key_value_url_decoder_core test failed");
    end
    $finish;
  end

endmodule

// File: form_key_value_url_decoder_core.f
+incdir+rtl
rtl/fkvud_pkg.sv
rtl/fkvud_front.sv
rtl/fkvud_queue.sv
rtl/fkvud_back.sv
rtl/form_key_value_url_decoder_core.sv
tb/form_key_value_url_decoder_core_checker.sv
tb/form_key_value_url_decoder_core_tb.sv
